// ----- rtl/itl_pkg.sv -----
// Shared types and constants for the interpolation table lookup unit.
package itl_pkg;

  // Field widths fixed by the request and result words
  localparam int REQ_W   = 2;
  localparam int ROW_W   = 8;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = KEY_W + VAL_W;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [ROW_W-1:0]        row_index;
    logic signed [KEY_W-1:0] key_in;
    logic [VAL_W-1:0]        row_value;
  } itl_in_t;

  typedef struct packed {
    logic                    status;
    logic signed [KEY_W-1:0] key_out;
    logic [VAL_W-1:0]        value_out;
  } itl_out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } itl_row_t;

  // One access to the row memory per cycle: write or read, never both
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ROW_W-1:0] addr;
    itl_row_t         wdata;
  } itl_mem_req_t;

endpackage

// ----- rtl/itl_table_mem.sv -----
// Row memory: one write and one read per cycle, registered read data.
module itl_table_mem #(
  parameter int ROWS = 32
) (
  input  logic                  clk,
  input  itl_pkg::itl_mem_req_t mem_req,
  output itl_pkg::itl_row_t     rd_row
);

  localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  itl_pkg::itl_row_t mem [ROWS];
  itl_pkg::itl_row_t rd_row_r;

  // Write the row, or fetch it into the read register
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr[IDX_W-1:0]] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_row_r <= mem[mem_req.addr[IDX_W-1:0]];
    end
  end

  assign rd_row = rd_row_r;

endmodule

// ----- rtl/itl_divider.sv -----
// Restoring divider: 48-bit dividend by 32-bit divisor, 16-bit quotient, one bit per cycle.
module itl_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [itl_pkg::PROD_W-1:0]   dividend,
  input  logic [itl_pkg::KEY_W-1:0]    divisor,
  output logic [itl_pkg::VAL_W-1:0]    quotient,
  output logic                         done
);

  localparam int KW = itl_pkg::KEY_W;
  localparam int VW = itl_pkg::VAL_W;
  localparam int CW = itl_pkg::DIV_CNT_W;

  logic [KW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] lo_r, lo_nxt;
  logic [KW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [KW:0]   trial;
  logic [KW:0]   diff;
  logic          qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, lo_r[VW-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // High part is below the divisor, so only the low bits yield quotient bits
      rem_nxt  = dividend[itl_pkg::PROD_W-1:VW];
      lo_nxt   = dividend[VW-1:0];
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[KW-1:0] : trial[KW-1:0];
      lo_nxt  = {lo_r[VW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(VW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    den_r <= den_nxt;
  end

  assign quotient = lo_r;
  assign done     = done_r;

endmodule

// ----- rtl/interp_table_lookup_unit.sv -----
// Top level of the interpolation table lookup unit: request control, scan and interpolation.
// Holds a calibration table of ROWS rows (signed 32-bit key, 16-bit value) in one
// synchronous memory and serves one request at a time. A row write or an out-of-range
// request goes from acceptance to the hold state, and a row read passes through the read
// state first. A lookup reads one row per cycle from row 0 until it meets a key at or above
// the search key or reaches the last row; when it interpolates it then passes through the
// multiply state for the 16x32 multiply, the divider start state and the one-bit-per-cycle
// divider. The finished result sits in an output register, and the next request is taken
// while it waits there.
module interp_table_lookup_unit #(
  parameter int ROWS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itl_pkg::itl_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output itl_pkg::itl_out_t out_word
);

  localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW    = itl_pkg::KEY_W;
  localparam int VW    = itl_pkg::VAL_W;
  localparam logic [itl_pkg::ROW_W:0] ROWS_LIM = (itl_pkg::ROW_W + 1)'(ROWS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DGO  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [2:0] state_r, state_nxt;

  itl_pkg::itl_mem_req_t mem_req;
  itl_pkg::itl_row_t     rd_row;

  logic signed [KW-1:0]      key_r, key_nxt;
  logic [IDX_W-1:0]          row_r, row_nxt;
  itl_pkg::itl_row_t         prev_r, prev_nxt;
  logic [VW-1:0]             yc_r, yc_nxt;
  logic [VW-1:0]             ady_r, ady_nxt;
  logic                      neg_r, neg_nxt;
  logic [KW-1:0]             adx_r, adx_nxt;
  logic [KW-1:0]             aden_r, aden_nxt;
  logic [itl_pkg::PROD_W-1:0] prod_r, prod_nxt;
  itl_pkg::itl_out_t         res_r, res_nxt;
  itl_pkg::itl_out_t         out_word_r, out_word_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      div_start;
  logic [VW-1:0]             div_q;
  logic                      div_done;

  logic                      in_fire;
  logic                      idx_ok;
  logic [KW:0]               dx_full;
  logic [KW:0]               den_full;
  logic [VW-1:0]             q_signed;

  itl_table_mem #(
    .ROWS (ROWS)
  ) u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_row  (rd_row)
  );

  itl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (aden_r),
    .quotient (div_q),
    .done     (div_done)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign idx_ok    = ({1'b0, in_word.row_index} < ROWS_LIM);
  assign div_start = (state_r == S_DGO);

  // Distances to the current row; both are positive once the scan stops between rows
  assign dx_full  = {rd_row.key[KW-1], rd_row.key} - {key_r[KW-1], key_r};
  assign den_full = {rd_row.key[KW-1], rd_row.key} - {prev_r.key[KW-1], prev_r.key};
  assign q_signed = neg_r ? (VW'(0) - div_q) : div_q;

  // Request sequencing, memory access and scan
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    row_nxt   = row_r;
    prev_nxt  = prev_r;
    yc_nxt    = yc_r;
    ady_nxt   = ady_r;
    neg_nxt   = neg_r;
    adx_nxt   = adx_r;
    aden_nxt  = aden_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    mem_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          mem_req.addr  = in_word.row_index;
          mem_req.wdata = '{key: in_word.key_in, value: in_word.row_value};
          unique case (in_word.req_type)
            itl_pkg::REQ_WRITE: begin
              mem_req.we     = idx_ok;
              res_nxt.status = idx_ok ? itl_pkg::ST_OK : itl_pkg::ST_FAIL;
              state_nxt      = S_HOLD;
            end
            itl_pkg::REQ_READ: begin
              mem_req.re     = idx_ok;
              res_nxt.status = idx_ok ? itl_pkg::ST_OK : itl_pkg::ST_FAIL;
              state_nxt      = idx_ok ? S_READ : S_HOLD;
            end
            itl_pkg::REQ_LOOKUP: begin
              mem_req.re   = 1'b1;
              mem_req.addr = '0;
              key_nxt      = in_word.key_in;
              row_nxt      = '0;
              state_nxt    = S_SCAN;
            end
            default: begin
              state_nxt = S_HOLD;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.key_out   = rd_row.key;
        res_nxt.value_out = rd_row.value;
        state_nxt         = S_HOLD;
      end
      S_SCAN: begin
        if ($signed(key_r) == $signed(rd_row.key)) begin
          res_nxt.value_out = rd_row.value;
          state_nxt         = S_HOLD;
        end else if ($signed(key_r) < $signed(rd_row.key)) begin
          if (row_r == '0) begin
            res_nxt.value_out = rd_row.value;
            state_nxt         = S_HOLD;
          end else begin
            // Capture the interpolation operands as magnitudes and a sign
            yc_nxt    = rd_row.value;
            neg_nxt   = (prev_r.value < rd_row.value);
            ady_nxt   = neg_nxt ? (rd_row.value - prev_r.value) : (prev_r.value - rd_row.value);
            adx_nxt   = dx_full[KW-1:0];
            aden_nxt  = den_full[KW-1:0];
            state_nxt = S_MUL;
          end
        end else if (row_r == IDX_W'(ROWS - 1)) begin
          res_nxt.value_out = rd_row.value;
          state_nxt         = S_HOLD;
        end else begin
          // Advance to the next row
          prev_nxt     = rd_row;
          row_nxt      = row_r + 1'b1;
          mem_req.re   = 1'b1;
          mem_req.addr = itl_pkg::ROW_W'(row_nxt);
        end
      end
      S_MUL: begin
        prod_nxt  = ady_r * adx_r;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt.value_out = yc_r + q_signed;
          state_nxt         = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load from the hold stage when the slot is free, drop on accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_HOLD && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    row_r      <= row_nxt;
    prev_r     <= prev_nxt;
    yc_r       <= yc_nxt;
    ady_r      <= ady_nxt;
    neg_r      <= neg_nxt;
    adx_r      <= adx_nxt;
    aden_r     <= aden_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide state");

  // The scan never walks past the last row
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> row_r <= IDX_W'(ROWS - 1))
    else $error("scan row beyond table");

  // The quotient fits 16 bits: high part of the product is below the divisor
  a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DGO |-> prod_r[itl_pkg::PROD_W-1:VW] < aden_r)
    else $error("interpolation quotient overflow");

  // A new result enters the output register only from the hold stage
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_HOLD)
    else $error("result loaded outside hold stage");

endmodule
